// ===== hw/rtl/cpf_pkg.sv =====
// Package for the command packet framer: queue entry type, constants and
// the CRC-8 / CRC-32 byte-update functions. No dependencies.
package cpf_pkg;

    localparam int CPF_QUEUE_DEPTH = 4;

    localparam logic [7:0]  CRC8_POLY   = 8'h07;
    localparam logic [31:0] CRC32_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC32_INIT  = 32'hFFFFFFFF;

    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_PAYLOAD = 1'b1;

    localparam logic [3:0] HDR_LAST_IDX = 4'd7;
    localparam logic [3:0] TRL_LEN      = 4'd4;

    // hdr: cmd, subcmd, type, seq, len lo, len hi from the low byte up;
    // for a payload word only hdr[7:0] is used.
    typedef struct packed {
        logic        is_start;
        logic        trailer;
        logic [47:0] hdr;
    } cpf_cmd_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC8_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ({1'b0, c[31:1]} ^ CRC32_POLY) : {1'b0, c[31:1]};
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/command_packet_framer_crc.sv =====
// Top level of the command packet framer with CRC-8 header and CRC-32 trailer.
// Instantiates cpf_front, cpf_queue and cpf_back; uses cpf_pkg.
//
//  channel | dir | tdata                                             | tuser      | tlast
//  s_      | in  | command, subcommand, packet_type, payload_length, | action     | -
//          |     | data_byte                                         |            |
//  m_      | out | out_byte                                          | packet_end | run_last
//
// Input words are taken one per cycle while the command queue has room;
// the back end sends one byte per cycle while m_tready allows, so a start word
// yields 8 bytes (12 with an empty payload), a payload byte 1 (5 with the trailer).
// Reset (aresetn low, synchronous) clears sequence, packet state and queue.
// The output register stalls only the back end; the front keeps accepting
// until the queue fills.
module command_packet_framer_crc #(
    parameter int QUEUE_DEPTH = cpf_pkg::CPF_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // command, subcommand, packet_type, payload_length, data_byte
    input  logic [0:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // packet_end
);
    import cpf_pkg::*;

    logic     push, q_full, pop, head_valid;
    cpf_cmd_t push_cmd, head_cmd;

    cpf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    cpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    cpf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

// ===== hw/rtl/cpf_front.sv =====
// Front end of the framer: accepts input words, tracks sequence and open
// packet state, and queues header or payload commands. Uses cpf_pkg.
module cpf_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,
    input  logic [0:0]        s_tuser,
    output logic              push,
    output cpf_pkg::cpf_cmd_t push_cmd,
    input  logic              q_full
);
    import cpf_pkg::*;

    logic [7:0]  seq_reg, seq_next;
    logic [15:0] remain_reg, remain_next;
    logic        open_reg, open_next;

    logic        accept;
    logic [15:0] plen;
    logic [15:0] flen;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign plen     = s_tdata[39:24];
    assign flen     = plen + 16'd4;

    always_comb begin
        seq_next          = seq_reg;
        remain_next       = remain_reg;
        open_next         = open_reg;
        push              = 1'b0;
        push_cmd.is_start = 1'b0;
        push_cmd.trailer  = 1'b0;
        push_cmd.hdr      = {40'd0, s_tdata[47:40]};
        if (accept) begin
            if (s_tuser[0] == ACT_START) begin
                push              = 1'b1;
                push_cmd.is_start = 1'b1;
                push_cmd.trailer  = (plen == 16'd0);
                push_cmd.hdr      = {flen, seq_reg, s_tdata[23:0]};
                seq_next          = seq_reg + 8'd1;
                open_next         = (plen != 16'd0);
                remain_next       = plen;
            end else if (open_reg) begin
                push             = 1'b1;
                push_cmd.trailer = (remain_reg == 16'd1);
                remain_next      = remain_reg - 16'd1;
                if (remain_reg == 16'd1) begin
                    open_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg    <= '0;
            remain_reg <= '0;
            open_reg   <= 1'b0;
        end else begin
            seq_reg    <= seq_next;
            remain_reg <= remain_next;
            open_reg   <= open_next;
        end
    end

endmodule

// ===== hw/rtl/cpf_queue.sv =====
// Small register FIFO of framer commands between front and back end.
// Uses cpf_pkg for the entry type.
module cpf_queue #(
    parameter int DEPTH = cpf_pkg::CPF_QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  cpf_pkg::cpf_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output cpf_pkg::cpf_cmd_t head_cmd
);
    import cpf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

    cpf_cmd_t      mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic do_push, do_pop;

    assign full       = (cnt_reg == CNT_MAX);
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = mem_reg[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_next  = do_push ? ((wr_reg == PTR_MAX) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = do_pop  ? ((rd_reg == PTR_MAX) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/cpf_back.sv =====
// Back end of the framer: walks the head command byte by byte, runs the
// header CRC-8 and packet CRC-32, and drives the registered output stream.
// Uses cpf_pkg.
module cpf_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  cpf_pkg::cpf_cmd_t head_cmd,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    output logic [0:0]        m_tuser
);
    import cpf_pkg::*;

    logic [3:0]  idx_reg, idx_next;
    logic [7:0]  crc8_reg, crc8_next;
    logic [31:0] crc32_reg, crc32_next;
    logic        vld_reg, vld_next;
    logic [7:0]  data_reg, data_next;
    logic        last_reg, last_next;
    logic        end_reg, end_next;

    logic        adv, fire, final_byte, in_trl;
    logic [3:0]  body_end, end_idx;
    logic [1:0]  tpos;
    logic [7:0]  byte_sel, crc8_base;
    logic [31:0] crc32_base, fin;

    assign adv      = !vld_reg || m_tready;
    assign fire     = adv && head_valid;
    assign body_end = head_cmd.is_start ? HDR_LAST_IDX : 4'd0;
    assign end_idx  = body_end + (head_cmd.trailer ? TRL_LEN : 4'd0);
    assign final_byte = (idx_reg == end_idx);
    assign in_trl   = (idx_reg > body_end);
    assign tpos     = 2'(idx_reg - body_end - 4'd1);
    assign fin      = ~crc32_reg;
    assign crc8_base  = (idx_reg == 4'd0) ? 8'd0 : crc8_reg;
    assign crc32_base = (head_cmd.is_start && idx_reg == 4'd0) ? CRC32_INIT : crc32_reg;
    assign pop      = fire && final_byte;

    always_comb begin
        byte_sel = head_cmd.hdr[7:0];
        if (in_trl) begin
            byte_sel = fin[8*tpos +: 8];
        end else if (head_cmd.is_start) begin
            case (idx_reg[2:0])
                3'd0:    byte_sel = head_cmd.hdr[7:0];
                3'd1:    byte_sel = head_cmd.hdr[15:8];
                3'd2:    byte_sel = head_cmd.hdr[23:16];
                3'd3:    byte_sel = head_cmd.hdr[31:24];
                3'd4:    byte_sel = head_cmd.hdr[39:32];
                3'd5:    byte_sel = head_cmd.hdr[47:40];
                3'd6:    byte_sel = ~crc8_reg;
                default: byte_sel = crc8_reg;
            endcase
        end
    end

    always_comb begin
        idx_next   = idx_reg;
        crc8_next  = crc8_reg;
        crc32_next = crc32_reg;
        vld_next   = vld_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        end_next   = end_reg;
        if (adv) begin
            vld_next = head_valid;
        end
        if (fire) begin
            data_next = byte_sel;
            last_next = final_byte;
            end_next  = final_byte && head_cmd.trailer;
            idx_next  = final_byte ? 4'd0 : idx_reg + 4'd1;
            if (head_cmd.is_start && idx_reg < 4'd6) begin
                crc8_next = crc8_byte(crc8_base, byte_sel);
            end
            if (in_trl) begin
                if (final_byte) begin
                    crc32_next = CRC32_INIT;
                end
            end else begin
                crc32_next = crc32_byte(crc32_base, byte_sel);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            crc8_reg  <= '0;
            crc32_reg <= CRC32_INIT;
            vld_reg   <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            crc8_reg  <= crc8_next;
            crc32_reg <= crc32_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
        end_reg  <= end_next;
    end

    assign m_tvalid   = vld_reg;
    assign m_tdata    = data_reg;
    assign m_tlast    = last_reg;
    assign m_tuser[0] = end_reg;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for command_packet_framer_crc: random and directed
// command/payload words, byte stream checked by a scoreboard class.
// Depends on cpf_pkg and the framer RTL.
`timescale 1ns / 1ps

module testbench;
    import cpf_pkg::*;

    localparam int LONG_HOLD   = 300;
    localparam int TOTAL_ITEMS = 130;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       packet_end;
    } frame_byte_t;

    class framer_scoreboard;
        bit [7:0]    seq_num;
        bit [31:0]   crc_reg;
        bit [15:0]   left;
        bit          is_open;
        frame_byte_t expected_bytes[$];
        int          errors;

        function new();
            seq_num = 8'd0;
            crc_reg = CRC32_INIT;
            left    = 16'd0;
            is_open = 1'b0;
            errors  = 0;
        endfunction

        function bit [7:0] crc8_update(bit [7:0] c, bit [7:0] b);
            bit fb;
            c = c ^ b;
            for (int i = 0; i < 8; i++) begin
                fb = c[7];
                c  = c << 1;
                if (fb) c = c ^ CRC8_POLY;
            end
            return c;
        endfunction

        function bit [31:0] crc32_update(bit [31:0] c, bit [7:0] b);
            bit fb;
            c[7:0] = c[7:0] ^ b;
            for (int i = 0; i < 8; i++) begin
                fb = c[0];
                c  = c >> 1;
                if (fb) c = c ^ CRC32_POLY;
            end
            return c;
        endfunction

        function void push(bit [7:0] b, bit last, bit pend);
            frame_byte_t e;
            e.out_byte   = b;
            e.run_last   = last;
            e.packet_end = pend;
            expected_bytes.push_back(e);
        endfunction

        function void close_packet();
            bit [31:0] fin;
            fin = ~crc_reg;
            for (int k = 0; k < 4; k++) begin
                push(fin[8*k +: 8], k == 3, k == 3);
            end
            crc_reg = CRC32_INIT;
            is_open = 1'b0;
            left    = 16'd0;
        endfunction

        // data: command, subcommand, packet_type, payload_length, data_byte
        function void note_word(bit act, bit [47:0] data);
            bit [7:0]  hdr [8];
            bit [15:0] plen;
            bit [15:0] flen;
            bit [7:0]  c8;
            bit [7:0]  b;
            if (act == ACT_START) begin
                plen   = data[39:24];
                flen   = plen + 16'd4;
                hdr[0] = data[7:0];
                hdr[1] = data[15:8];
                hdr[2] = data[23:16];
                hdr[3] = seq_num;
                hdr[4] = flen[7:0];
                hdr[5] = flen[15:8];
                c8     = 8'd0;
                for (int k = 0; k < 6; k++) c8 = crc8_update(c8, hdr[k]);
                hdr[6]  = ~c8;
                hdr[7]  = c8;
                seq_num = seq_num + 8'd1;
                crc_reg = CRC32_INIT;
                for (int k = 0; k < 8; k++) begin
                    crc_reg = crc32_update(crc_reg, hdr[k]);
                    push(hdr[k], (k == 7) && (plen != 16'd0), 1'b0);
                end
                is_open = 1'b1;
                left    = plen;
                if (plen == 16'd0) close_packet();
            end else if (is_open) begin
                b       = data[47:40];
                crc_reg = crc32_update(crc_reg, b);
                left    = left - 16'd1;
                if (left == 16'd0) begin
                    push(b, 1'b0, 1'b0);
                    close_packet();
                end else begin
                    push(b, 1'b1, 1'b0);
                end
            end
        endfunction

        function void check_byte(bit [7:0] b, bit last, bit pend);
            frame_byte_t e;
            if (expected_bytes.size() == 0) begin
                $error("unexpected output word: out_byte %02h", b);
                errors++;
                return;
            end
            e = expected_bytes.pop_front();
            if (b !== e.out_byte) begin
                $error("out_byte: expected %02h, actual %02h", e.out_byte, b);
                errors++;
            end
            if (last !== e.run_last) begin
                $error("run_last: expected %0d, actual %0d", e.run_last, last);
                errors++;
            end
            if (pend !== e.packet_end) begin
                $error("packet_end: expected %0d, actual %0d", e.packet_end, pend);
                errors++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = 48'd0;
    logic [0:0]  s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    framer_scoreboard sb = new();

    bit hold_req   = 1'b0;
    bit quiet      = 1'b0;
    int idle_level = 1;
    int words_sent = 0;

    command_packet_framer_crc dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_word(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready) sb.check_byte(m_tdata, m_tlast, m_tuser[0]);
        end
    end

    task automatic send_word(input bit act, input bit [47:0] data);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic sender_gap();
        int n;
        if (!quiet && idle_level != 0 && $urandom_range(0, 9) < idle_level * 2) begin
            n = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send_start(input bit [7:0] cmd, input bit [7:0] sub,
                              input bit [7:0] typ, input bit [15:0] len);
        bit [7:0] noise;
        noise = 8'($urandom);
        sender_gap();
        send_word(ACT_START, {noise, len, typ, sub, cmd});
        words_sent++;
    endtask

    task automatic send_payload(input bit [7:0] db);
        bit [47:0] w;
        w = {16'($urandom), $urandom};
        w[47:40] = db;
        sender_gap();
        send_word(ACT_PAYLOAD, w);
        words_sent++;
    endtask

    task automatic send_packet(input bit [15:0] len, input int n_bytes);
        send_start(8'($urandom), 8'($urandom), 8'($urandom), len);
        for (int i = 0; i < n_bytes; i++) send_payload(8'($urandom));
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end else if (!quiet && idle_level != 0 && $urandom_range(0, 15) < idle_level) begin
                n = $urandom_range(1, 9);
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #(2_000_000);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int r;
        int len;
        int cnt;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed
        send_payload(8'h5A);                        // no packet open: dropped
        send_start(8'h00, 8'h00, 8'h00, 16'd0);     // empty payload
        send_start(8'hFF, 8'hFF, 8'hFF, 16'd1);
        send_payload(8'hFF);
        send_start(8'h01, 8'h80, 8'h7F, 16'd2);
        send_payload(8'h00);
        send_payload(8'hA5);
        send_start(8'hAA, 8'h55, 8'h0F, 16'hFFFF);  // length field wraps
        send_payload(8'h12);
        send_start(8'h3C, 8'hC3, 8'hF0, 16'hFFFC);  // abandons the open packet
        send_start(8'h5A, 8'hA5, 8'h01, 16'hFFFB);
        send_start(8'h12, 8'h34, 8'h56, 16'hAAAA);
        send_start(8'h65, 8'h43, 8'h21, 16'h5555);
        send_start(8'hDE, 8'hAD, 8'hBE, 16'd3);
        send_payload(8'h00);
        send_payload(8'hFF);
        send_payload(8'h80);
        send_payload(8'h77);                        // after trailer: dropped
        send_start(8'hC0, 8'hDE, 8'h02, 16'd0);

        // random
        hold_req = 1'b1;
        while (words_sent < TOTAL_ITEMS) begin
            if (words_sent >= TOTAL_ITEMS - 25) begin
                quiet      = 1'b1;
                idle_level = 0;
            end else begin
                idle_level = $urandom_range(0, 3);
            end
            r = $urandom_range(0, 99);
            if (r < 75) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(0, 12);
                send_packet(16'(len), len);
            end else if (r < 88) begin
                len = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 12)
                                                  : $urandom_range(1, 65535);
                cnt = $urandom_range(0, (len > 6) ? 5 : len - 1);
                send_packet(16'(len), cnt);
            end else begin
                cnt = $urandom_range(1, 3);
                for (int i = 0; i < cnt; i++) send_payload(8'($urandom));
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
